// ===== hdl/lorentzian_model_gradient_top_assert.svh =====
// Assertion macros for the Lorentzian model and gradient block.
// Depends on a clk and an arst_n signal in the scope that uses them.
`ifndef LORENTZIAN_MODEL_GRADIENT_TOP_ASSERT_SVH
`define LORENTZIAN_MODEL_GRADIENT_TOP_ASSERT_SVH

// Clocked implication check, disabled while reset is asserted.
`define LMG_CHECK(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Clocked check that a condition never holds, disabled while reset is asserted.
`define LMG_NEVER(label, bad, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(bad)) \
		else $error(msg);

`endif

// ===== hdl/lmg_pkg.sv =====
// Shared constants, types and helper functions of the Lorentzian model block.
// No dependencies; used by every module of the block.
package lmg_pkg;

	// Fixed point format of all ports.
	localparam int DATA_W = 32;
	localparam int FRAC_BITS = 16;
	localparam int OUT_W = (DATA_W < 32) ? DATA_W : 32;
	localparam int CW = 31;

	// Divider geometry: quotient bits per division, divisor and numerator widths.
	localparam int QB = OUT_W + 1;
	localparam int MW = 2 * DATA_W + 1;
	localparam int NW = 2 * DATA_W + FRAC_BITS + 1;
	localparam int GW = FRAC_BITS + 1;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_AMPLITUDE  = 2'd0,
		REG_CENTRE     = 2'd1,
		REG_HALF_WIDTH = 2'd2,
		REG_OFFSET     = 2'd3
	} reg_idx_t;

	// One divider cell's view of a beat in flight.
	typedef struct packed {
		logic          v;
		logic [MW-1:0] r;
		logic [QB-1:0] n;
		logic [QB-1:0] q;
		logic [MW-1:0] m;
	} div_cell_t;

	// Side data that travels next to the first divider chain.
	typedef struct packed {
		logic [DATA_W-1:0]   aa;
		logic                neg_a;
		logic                neg_u;
		logic [DATA_W-1:0]   offs;
		logic                cz;
		logic [2*DATA_W-1:0] pau;
		logic [2*DATA_W-2:0] pac;
	} sb1_t;

	// Side data that travels next to the second pair of divider chains.
	typedef struct packed {
		logic [OUT_W-1:0] model;
		logic [GW-1:0]    gq;
		logic             neg_c;
		logic             neg_a;
		logic             cz;
		logic             ovc;
		logic             ovw;
	} sb2_t;

	// Round a quotient half up from its remainder, saturate and apply the sign.
	function automatic logic [OUT_W-1:0] sat_round(
		input logic [QB-1:0] q,
		input logic [MW-1:0] r,
		input logic [MW-1:0] m,
		input logic          ov,
		input logic          neg
	);
		logic          rnd;
		logic [QB:0]   mag;
		logic [QB:0]   lim;
		logic [OUT_W-1:0] res;
		rnd = ({r, 1'b0} >= {1'b0, m});
		mag = {1'b0, q} + {{QB{1'b0}}, rnd};
		lim = neg ? ({{(QB-OUT_W+1){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}})
		          : ({{(QB-OUT_W+2){1'b0}}, {(OUT_W-1){1'b1}}});
		if (ov || (mag > lim)) begin
			mag = lim;
		end
		res = neg ? (~mag[OUT_W-1:0] + {{(OUT_W-1){1'b0}}, 1'b1}) : mag[OUT_W-1:0];
		return res;
	endfunction

endpackage

// ===== hdl/lmg_div_cell.sv =====
// One restoring division step: shifts in a numerator bit and subtracts the divisor.
// Depends on lmg_pkg.
module lmg_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  lmg_pkg::div_cell_t d,
	output lmg_pkg::div_cell_t o
);

	logic                    v_q;
	lmg_pkg::div_cell_t      pay_q;
	lmg_pkg::div_cell_t      nxt;
	logic [lmg_pkg::MW:0]    rs;
	logic [lmg_pkg::MW:0]    diff;
	logic                    ge;

	// Trial subtraction of the divisor from the shifted remainder.
	always_comb begin
		rs = {d.r, d.n[lmg_pkg::QB-1]};
		diff = rs - {1'b0, d.m};
		ge = (rs >= {1'b0, d.m});
		nxt.v = d.v;
		nxt.r = ge ? diff[lmg_pkg::MW-1:0] : rs[lmg_pkg::MW-1:0];
		nxt.n = {d.n[lmg_pkg::QB-2:0], 1'b0};
		nxt.q = {d.q[lmg_pkg::QB-2:0], ge};
		nxt.m = d.m;
	end

	// Valid bit of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= d.v;
		end
	end

	// Payload of the cell.
	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		o = pay_q;
		o.v = v_q;
	end

endmodule

// ===== hdl/lmg_div_chain.sv =====
// A row of division cells that yields one quotient bit per cell.
// Depends on lmg_pkg and lmg_div_cell.
module lmg_div_chain (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  lmg_pkg::div_cell_t d,
	output lmg_pkg::div_cell_t o
);

	lmg_pkg::div_cell_t link [lmg_pkg::QB+1];

	assign link[0] = d;

	// Each cell hands its partial remainder and quotient to the next one.
	for (genvar i = 0; i < lmg_pkg::QB; i++) begin : g_cell
		lmg_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (link[i]),
			.o      (link[i+1])
		);
	end

	assign o = link[lmg_pkg::QB];

endmodule

// ===== hdl/lorentzian_model_gradient_top.sv =====
// Top level of the Lorentzian model and gradient block.
// Depends on lmg_pkg, lmg_div_chain and lorentzian_model_gradient_top_assert.svh.
//
// One sample x_value enters per clock cycle and one result beat leaves per
// cycle while results are read, so long sample vectors stream at full rate.
// A sample passes registered stages of distance, squares and products, a chain
// of 33 division cells for the fraction C^2/(C^2+u^2), registered stages of
// rounding and products, a second pair of 33-cell chains for the centre and
// width derivatives, and the output register. The whole pipeline stalls
// together while a result waits unread. Results saturate to the signed 32-bit
// range; a zero half width sets div_error and zeroes the other result fields.
module lorentzian_model_gradient_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] x_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] model_value,
	output logic [31:0] d_amplitude,
	output logic [31:0] d_centre,
	output logic [31:0] d_width,
	output logic        div_error
);

	localparam int DW = lmg_pkg::DATA_W;
	localparam int QB = lmg_pkg::QB;
	localparam int MW = lmg_pkg::MW;
	localparam int NW = lmg_pkg::NW;
	localparam int GW = lmg_pkg::GW;
	localparam int FB = lmg_pkg::FRAC_BITS;
	localparam int OW = lmg_pkg::OUT_W;

	// Configuration registers.
	logic [DW-1:0]            amplitude_q;
	logic [DW-1:0]            centre_q;
	logic [lmg_pkg::CW-1:0]   half_width_q;
	logic [DW-1:0]            offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q  <= DW'(65536);
			centre_q     <= '0;
			half_width_q <= lmg_pkg::CW'(65536);
			offset_q     <= '0;
		end else if (cfg_we) begin
			unique case (lmg_pkg::reg_idx_t'(cfg_index))
				lmg_pkg::REG_AMPLITUDE:  amplitude_q  <= cfg_data;
				lmg_pkg::REG_CENTRE:     centre_q     <= cfg_data;
				lmg_pkg::REG_HALF_WIDTH: half_width_q <= cfg_data[lmg_pkg::CW-1:0];
				lmg_pkg::REG_OFFSET:     offset_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves when the output register is free or being read.
	logic en;
	logic out_valid_q;
	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	// Stage 1: distance from the centre and magnitudes.
	logic                     v_s1;
	logic [DW:0]              u_w;
	logic [DW-1:0]            au_s1, aa_s1, offs_s1;
	logic [lmg_pkg::CW-1:0]   c_s1;
	logic                     neg_u_s1, neg_a_s1;

	assign u_w = {x_value[DW-1], x_value} - {centre_q[DW-1], centre_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_u_s1 <= u_w[DW];
			au_s1    <= u_w[DW] ? DW'(-u_w) : u_w[DW-1:0];
			neg_a_s1 <= amplitude_q[DW-1];
			aa_s1    <= amplitude_q[DW-1] ? (~amplitude_q + DW'(1)) : amplitude_q;
			c_s1     <= half_width_q;
			offs_s1  <= offset_q;
		end
	end

	// Stage 2: squares and amplitude products.
	logic                   v_s2;
	logic [2*DW-1:0]        csq_s2, usq_s2;
	lmg_pkg::sb1_t          sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			csq_s2      <= (2*DW)'(c_s1 * c_s1);
			usq_s2      <= au_s1 * au_s1;
			sb_s2.aa    <= aa_s1;
			sb_s2.neg_a <= neg_a_s1;
			sb_s2.neg_u <= neg_u_s1;
			sb_s2.offs  <= offs_s1;
			sb_s2.cz    <= (c_s1 == '0);
			sb_s2.pau   <= aa_s1 * au_s1;
			sb_s2.pac   <= (2*DW-1)'(aa_s1 * c_s1);
		end
	end

	// Stage 3: divisor and numerator of the fraction.
	logic                   v_s3;
	logic [MW-1:0]          m_s3;
	logic [NW-1:0]          n_s3;
	lmg_pkg::sb1_t          sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3  <= {1'b0, csq_s2} + {1'b0, usq_s2};
			n_s3  <= NW'({csq_s2, {FB{1'b0}}});
			sb_s3 <= sb_s2;
		end
	end

	// First division chain: fraction g with its side data alongside.
	lmg_pkg::div_cell_t d1_in, d1_out;
	lmg_pkg::sb1_t      sbl1_q [QB];

	always_comb begin
		d1_in.v = v_s3;
		d1_in.r = MW'(n_s3[NW-1:QB]);
		d1_in.n = n_s3[QB-1:0];
		d1_in.q = '0;
		d1_in.m = m_s3;
	end

	lmg_div_chain u_chain_g (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (d1_in),
		.o      (d1_out)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sbl1_q[0] <= sb_s3;
			for (int i = 1; i < QB; i++) begin
				sbl1_q[i] <= sbl1_q[i-1];
			end
		end
	end

	// Stage 4: rounded fraction.
	logic                   v_s4;
	logic [GW-1:0]          gq_s4;
	logic [MW-1:0]          m_s4;
	lmg_pkg::sb1_t          sb_s4;
	logic                   g_rnd;
	logic [GW:0]            g_sum;

	assign g_rnd = ({d1_out.r, 1'b0} >= {1'b0, d1_out.m});
	assign g_sum = {1'b0, d1_out.q[GW-1:0]} + {{GW{1'b0}}, g_rnd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= d1_out.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gq_s4 <= g_sum[GW-1:0];
			m_s4  <= d1_out.m;
			sb_s4 <= sbl1_q[QB-1];
		end
	end

	// Stage 5: partial products of the derivative numerators and the model.
	logic                   v_s5;
	logic [GW-1:0]          hq_w;
	logic [DW+GW-1:0]       pau_hi_s5, pau_lo_s5, pac_hi_s5, pac_lo_s5, mv_s5;
	logic [GW-1:0]          gq_s5;
	logic [MW-1:0]          m_s5;
	lmg_pkg::sb1_t          sb_s5;

	assign hq_w = GW'(1 << FB) - gq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pau_hi_s5 <= sb_s4.pau[2*DW-1:DW] * gq_s4;
			pau_lo_s5 <= sb_s4.pau[DW-1:0] * gq_s4;
			pac_hi_s5 <= (DW+GW)'(sb_s4.pac[2*DW-2:DW] * hq_w);
			pac_lo_s5 <= sb_s4.pac[DW-1:0] * hq_w;
			mv_s5     <= sb_s4.aa * gq_s4;
			gq_s5     <= gq_s4;
			m_s5      <= m_s4;
			sb_s5     <= sb_s4;
		end
	end

	// Stage 6: numerators, overflow checks and the saturated model value.
	logic                   v_s6;
	logic [NW-1:0]          nc_w, nw_w;
	logic [DW:0]            rq_w;
	logic signed [DW+2:0]   val_w;
	logic [OW-1:0]          model_w;
	logic [MW-1:0]          m_s6;
	logic [NW-1:0]          nc_s6, nw_s6;
	lmg_pkg::sb2_t          sb_s6;

	always_comb begin
		nc_w = NW'({({pau_hi_s5, {DW{1'b0}}} + NW'(pau_lo_s5)), 1'b0});
		nw_w = NW'({({pac_hi_s5, {DW{1'b0}}} + NW'(pac_lo_s5)), 1'b0});
		rq_w = (DW+1)'((mv_s5 + (DW+GW)'(1 << (FB-1))) >> FB);
		val_w = (sb_s5.neg_a ? -$signed({2'b00, rq_w}) : $signed({2'b00, rq_w}))
		        + (DW+3)'($signed(sb_s5.offs));
		if (val_w > $signed((DW+3)'((64'd1 << (OW-1)) - 64'd1))) begin
			model_w = {1'b0, {(OW-1){1'b1}}};
		end else if (val_w < -$signed((DW+3)'(64'd1 << (OW-1)))) begin
			model_w = {1'b1, {(OW-1){1'b0}}};
		end else begin
			model_w = val_w[OW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nc_s6       <= nc_w;
			nw_s6       <= nw_w;
			m_s6        <= m_s5;
			sb_s6.model <= model_w;
			sb_s6.gq    <= gq_s5;
			sb_s6.neg_c <= sb_s5.neg_a ^ sb_s5.neg_u;
			sb_s6.neg_a <= sb_s5.neg_a;
			sb_s6.cz    <= sb_s5.cz;
			sb_s6.ovc   <= (MW'(nc_w[NW-1:QB]) >= m_s5);
			sb_s6.ovw   <= (MW'(nw_w[NW-1:QB]) >= m_s5);
		end
	end

	// Second pair of division chains: centre and width derivatives.
	lmg_pkg::div_cell_t dc_in, dc_out, dw_in, dw_out;
	lmg_pkg::sb2_t      sbl2_q [QB];

	always_comb begin
		dc_in.v = v_s6;
		dc_in.r = MW'(nc_s6[NW-1:QB]);
		dc_in.n = nc_s6[QB-1:0];
		dc_in.q = '0;
		dc_in.m = m_s6;
		dw_in.v = v_s6;
		dw_in.r = MW'(nw_s6[NW-1:QB]);
		dw_in.n = nw_s6[QB-1:0];
		dw_in.q = '0;
		dw_in.m = m_s6;
	end

	lmg_div_chain u_chain_c (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (dc_in),
		.o      (dc_out)
	);

	lmg_div_chain u_chain_w (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (dw_in),
		.o      (dw_out)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sbl2_q[0] <= sb_s6;
			for (int i = 1; i < QB; i++) begin
				sbl2_q[i] <= sbl2_q[i-1];
			end
		end
	end

	// Output register: rounding, saturation and the zero width case.
	lmg_pkg::sb2_t sb_o;
	logic [OW-1:0] model_q, d_amp_q, d_cen_q, d_wid_q;
	logic          err_q;

	assign sb_o = sbl2_q[QB-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dc_out.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_q <= sb_o.cz;
			if (sb_o.cz) begin
				model_q <= '0;
				d_amp_q <= '0;
				d_cen_q <= '0;
				d_wid_q <= '0;
			end else begin
				model_q <= sb_o.model;
				d_amp_q <= OW'(sb_o.gq);
				d_cen_q <= lmg_pkg::sat_round(dc_out.q, dc_out.r, dc_out.m,
					sb_o.ovc, sb_o.neg_c);
				d_wid_q <= lmg_pkg::sat_round(dw_out.q, dw_out.r, dw_out.m,
					sb_o.ovw, sb_o.neg_a);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign model_value = 32'(model_q);
	assign d_amplitude = 32'(d_amp_q);
	assign d_centre    = 32'(d_cen_q);
	assign d_width     = 32'(d_wid_q);
	assign div_error   = err_q;

	// Checks on the result beats.
`include "lorentzian_model_gradient_top_assert.svh"

	`LMG_CHECK(a_err_zero, out_valid && div_error,
		model_value == '0 && d_amplitude == '0 && d_centre == '0 && d_width == '0,
		"zero half width result carries nonzero fields")
	`LMG_CHECK(a_frac_range, out_valid && !div_error,
		d_amplitude <= 32'(1 << FB),
		"amplitude derivative exceeds one")
	`LMG_NEVER(a_stall_hold, out_valid && !out_ready && in_ready,
		"input taken while the output beat is stalled")

endmodule
